[hw/rtl/lpht_pkg.sv]
// Shared types and codes for the linear probing hash table.
package lpht_pkg;

  localparam int unsigned CntW  = 11;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REPLACE = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_LOOKUP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_REPLACED  = 3'd2,
    ST_DELETED   = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    MARK_UNUSED = 2'd0,
    MARK_LIVE   = 2'd1,
    MARK_TOMB   = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_PROBE,
    S_OUT
  } state_e;

  typedef struct packed {
    cmd_e             command;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] data;
  } in_t;

  typedef struct packed {
    status_e          status;
    logic [DataW-1:0] old_data;
    logic [CntW-1:0]  entry_count;
    logic [CntW-1:0]  deleted_count;
  } out_t;

  typedef struct packed {
    logic [1:0]       mark;
    logic [KeyW-1:0]  key;
    logic [DataW-1:0] value;
  } row_t;

endpackage

[hw/rtl/lpht_mod_unit.sv]
// Bit-serial remainder unit: key modulo bucket count, one dividend bit per cycle.
module lpht_mod_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [31:0]               dividend_i,
  input  logic [lpht_pkg::CntW-1:0] divisor_i,
  output logic                      done_o,
  output logic [lpht_pkg::CntW-1:0] rem_o
);
  import lpht_pkg::*;

  logic            busy_q;
  logic [4:0]      cnt_q;
  logic [31:0]     dvd_q;
  logic [CntW:0]   rem_q;
  logic [CntW-1:0] dvs_q;
  logic            done_q;
  logic [CntW:0]   trial;

  assign trial = {rem_q[CntW-1:0], dvd_q[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 5'd0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) busy_q <= 1'b0;
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) rem_q <= trial - {1'b0, dvs_q};
      else rem_q <= trial;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[CntW-1:0];

endmodule

[hw/rtl/lpht_bucket_ram.sv]
// Bucket memory: mark, key and data per bucket, one write and one registered read port.
module lpht_bucket_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  lpht_pkg::row_t   wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output lpht_pkg::row_t   rdata_o
);
  import lpht_pkg::*;

  row_t mem [Depth];
  row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/linear_probe_hash_table.sv]
// Linear probing hash table: 32-bit keys to 32-bit data, one result per command.
//
// One transaction at a time. When a transaction is taken, its key goes straight
// into a bit-serial remainder unit, and the home bucket (key modulo the
// effective bucket count) is ready once that unit is done. The probe walk then
// reads one bucket per cycle from the single-read-port bucket memory, visiting
// 1 .. bucket count buckets. The hand-off step then passes the result to the
// output register. The next transaction is taken only once the controller is
// back in idle. A stalled result holds the controller in its hand-off step only
// while the output register is still occupied. The output register lets the
// next transaction enter while a result still waits. After reset the block
// sweeps all TABLE_DEPTH buckets to unused, one per cycle, and holds
// in_stall_o high throughout the sweep; configuration writes are taken
// during it too. A bucket_count of 0 acts as 1 and one above TABLE_DEPTH
// acts as TABLE_DEPTH. Write bucket_count only while the block is idle.
module linear_probe_hash_table #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lpht_pkg::in_t             in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lpht_pkg::out_t            out_o,
  input  logic                      cfg_we_i,
  input  logic [lpht_pkg::CntW-1:0] cfg_wdata_i
);
  import lpht_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (AW > CntW) ? AW : CntW;

  state_e state_q, state_d;

  // configuration
  logic [CntW-1:0] bcount_q;
  logic [CntW-1:0] n_eff;

  // latched command
  cmd_e             cmd_q;
  logic [KeyW-1:0]  key_q;
  logic [DataW-1:0] data_q;

  // probe walk
  logic [AW-1:0]   cur_q;
  logic [CntW-1:0] steps_q;
  logic            tomb_seen_q;
  logic [AW-1:0]   tomb_at_q;
  logic [AW-1:0]   clr_q;

  logic [NW-1:0] live_q, tomb_q, live_d, tomb_d;

  // result held between probe end and output register
  status_e          res_status_q, res_status_d;
  logic [DataW-1:0] res_old_q, res_old_d;

  out_t out_q;
  logic out_valid_q;

  // remainder unit
  logic            div_start;
  logic            div_done;
  logic [CntW-1:0] div_rem;

  // memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  row_t          mem_wdata;
  logic [AW-1:0] mem_raddr;
  row_t          mem_rdata;

  logic          accept;
  logic          out_free;
  logic          finish;
  logic          is_unused, is_tomb, is_hit, is_last, has_slot, from_tomb;
  logic [AW-1:0] slot;
  logic [AW-1:0] nxt;
  logic [IW:0]   nxt_wide;
  logic [AW-1:0] home;

  assign n_eff = (bcount_q == '0) ? CntW'(1) :
                 (32'(bcount_q) > TABLE_DEPTH) ? CntW'(TABLE_DEPTH) : bcount_q;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign home     = AW'(div_rem);

  // The remainder starts at the accepting edge, so it takes the key from the port.
  lpht_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_i.key),
    .divisor_i  (n_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  lpht_bucket_ram #(
    .Depth (TABLE_DEPTH),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Bucket under evaluation is cur_q; its row arrives this cycle.
  assign is_unused = mem_rdata.mark == MARK_UNUSED;
  assign is_tomb   = mem_rdata.mark == MARK_TOMB;
  assign is_hit    = (mem_rdata.mark == MARK_LIVE) && (mem_rdata.key == key_q);
  assign is_last   = steps_q == (n_eff - CntW'(1));
  assign finish    = (state_q == S_PROBE) && (is_unused || is_hit || is_last);

  // Insert position: first tombstone met, else the unused bucket that stopped us.
  assign slot      = tomb_seen_q ? tomb_at_q : cur_q;
  assign has_slot  = is_unused || tomb_seen_q || is_tomb;
  assign from_tomb = tomb_seen_q || (!is_unused && is_tomb);

  // Next bucket with wraparound at the effective count.
  assign nxt_wide = (IW+1)'(cur_q) + (IW+1)'(1);
  assign nxt      = (nxt_wide >= (IW+1)'(n_eff)) ? '0 : AW'(nxt_wide);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == AW'(TABLE_DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_PROBE;
      S_PROBE: if (finish) state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // Outputs of the controller: memory port, remainder start, result decision
  always_comb begin
    in_stall_o   = state_q != S_IDLE;
    div_start    = (state_q == S_IDLE) && accept;
    mem_raddr    = (state_q == S_DIV) ? home : nxt;
    mem_we       = 1'b0;
    mem_waddr    = cur_q;
    mem_wdata    = '0;
    live_d       = live_q;
    tomb_d       = tomb_q;
    res_status_d = res_status_q;
    res_old_d    = res_old_q;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      S_PROBE: begin
        if (finish) begin
          res_old_d = '0;
          case (cmd_q)
            CMD_INSERT, CMD_REPLACE: begin
              if (is_hit) begin
                res_old_d = mem_rdata.value;
                if (cmd_q == CMD_REPLACE) begin
                  res_status_d = ST_REPLACED;
                  mem_we       = 1'b1;
                  mem_wdata    = '{mark: MARK_LIVE, key: key_q, value: data_q};
                end else begin
                  res_status_d = ST_EXISTS;
                end
              end else if (!has_slot) begin
                res_status_d = ST_FULL;
              end else begin
                res_status_d = ST_INSERTED;
                mem_we       = 1'b1;
                mem_waddr    = slot;
                mem_wdata    = '{mark: MARK_LIVE, key: key_q, value: data_q};
                live_d       = live_q + NW'(1);
                if (from_tomb) tomb_d = tomb_q - NW'(1);
              end
            end
            CMD_DELETE: begin
              if (is_hit) begin
                res_status_d = ST_DELETED;
                res_old_d    = mem_rdata.value;
                mem_we       = 1'b1;
                mem_wdata    = '{mark: MARK_TOMB, key: '0, value: '0};
                live_d       = live_q - NW'(1);
                tomb_d       = tomb_q + NW'(1);
              end else begin
                res_status_d = ST_NOT_FOUND;
              end
            end
            default: begin
              if (is_hit) begin
                res_status_d = ST_FOUND;
                res_old_d    = mem_rdata.value;
              end else begin
                res_status_d = ST_NOT_FOUND;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      bcount_q    <= CntW'(1021);
      clr_q       <= '0;
      live_q      <= '0;
      tomb_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) bcount_q <= cfg_wdata_i;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      live_q <= live_d;
      tomb_q <= tomb_d;
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_i.command;
      key_q  <= in_i.key;
      data_q <= in_i.data;
    end
    res_status_q <= res_status_d;
    res_old_q    <= res_old_d;
    if (state_q == S_DIV && div_done) begin
      cur_q       <= home;
      steps_q     <= '0;
      tomb_seen_q <= 1'b0;
      tomb_at_q   <= '0;
    end else if (state_q == S_PROBE && !finish) begin
      cur_q   <= nxt;
      steps_q <= steps_q + CntW'(1);
      if (is_tomb && !tomb_seen_q) begin
        tomb_seen_q <= 1'b1;
        tomb_at_q   <= cur_q;
      end
    end
    if (state_q == S_OUT && out_free) begin
      out_q.status        <= res_status_q;
      out_q.old_data      <= res_old_q;
      out_q.entry_count   <= CntW'(live_q);
      out_q.deleted_count <= CntW'(tomb_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Live entries and tombstones each occupy a bucket of their own.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(live_q) + 32'(tomb_q)) <= TABLE_DEPTH)
    else $error("live plus tombstone count exceeds table depth");

  // The walk never leaves the buckets in use.
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROBE |-> (CntW+AW)'(cur_q) < (CntW+AW)'(n_eff))
    else $error("probe address beyond bucket count");

  // A remainder only arrives while the controller waits for it.
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("remainder done outside of home bucket wait");

  // A new result only follows the result hand-off step.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q ##1 out_valid_q |-> $past(state_q) == S_OUT)
    else $error("result appeared without a finished command");

endmodule
